FILE: design/aocs_pkg.sv
// aocs_pkg: field widths, calibration constants, result type and the offset step
// function of the offset calibration sequencer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none
package aocs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ZONE_W   = 4;
    localparam int OFFSET_W = 6;
    localparam int ADDR_W   = 10;
    localparam int WORD_W   = 16;

    localparam logic [SAMPLE_W-1:0] MID_LEVEL = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] THRESH_HI = 16'hE000;
    localparam logic [SAMPLE_W-1:0] THRESH_MD = 16'hC000;
    localparam logic [SAMPLE_W-1:0] THRESH_LO = 16'h9000;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 6'd63;
    localparam logic [ADDR_W-1:0]   ADDR_BASE  = 10'h082;

    // request codes
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic REG_DIFF_MODE  = 1'b0;
    localparam logic REG_ZONE_COUNT = 1'b1;

    typedef struct packed {
        logic                write_valid;
        logic [ADDR_W-1:0]   reg_address;
        logic [WORD_W-1:0]   write_word;
        logic [ZONE_W-1:0]   zone_index;
        logic                zone_done;
        logic [OFFSET_W-1:0] pos_offset_out;
        logic [OFFSET_W-1:0] neg_offset_out;
        logic                all_done;
    } res_t;

    // Grow an offset by a step picked from the sample level, saturate at the maximum.
    function automatic logic [OFFSET_W-1:0] offset_step(input logic [OFFSET_W-1:0] off,
                                                        input logic [SAMPLE_W-1:0] s);
        logic [OFFSET_W-1:0] inc;
        logic [OFFSET_W:0]   sum;
        if (s > THRESH_HI)
            inc = 6'd16;
        else if (s > THRESH_MD)
            inc = 6'd8;
        else if (s > THRESH_LO)
            inc = 6'd4;
        else
            inc = 6'd1;
        sum = {1'b0, off} + {1'b0, inc};
        if (sum > {1'b0, OFFSET_MAX})
            return OFFSET_MAX;
        return sum[OFFSET_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/aocs_req_if.sv
// aocs_req_if: request channel (start or sample) of the calibration sequencer.
// Depends on aocs_pkg for field widths.
`default_nettype none
interface aocs_req_if;
    import aocs_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface
`default_nettype wire

FILE: design/aocs_res_if.sv
// aocs_res_if: result channel carrying one offset write / status per request.
// Depends on aocs_pkg for field widths.
`default_nettype none
interface aocs_res_if;
    import aocs_pkg::*;

    logic                valid;
    logic                ready;
    logic                write_valid;
    logic [ADDR_W-1:0]   reg_address;
    logic [WORD_W-1:0]   write_word;
    logic [ZONE_W-1:0]   zone_index;
    logic                zone_done;
    logic [OFFSET_W-1:0] pos_offset_out;
    logic [OFFSET_W-1:0] neg_offset_out;
    logic                all_done;

    modport source (output valid, output write_valid, output reg_address, output write_word,
                    output zone_index, output zone_done, output pos_offset_out,
                    output neg_offset_out, output all_done, input ready);
    modport sink   (input valid, input write_valid, input reg_address, input write_word,
                    input zone_index, input zone_done, input pos_offset_out,
                    input neg_offset_out, input all_done, output ready);
endinterface
`default_nettype wire

FILE: design/aocs_cfg_if.sv
// aocs_cfg_if: configuration write channel (register index and write data).
// Depends on aocs_pkg for the data width.
`default_nettype none
interface aocs_cfg_if;
    import aocs_pkg::*;

    logic              valid;
    logic              ready;
    logic              reg_index;
    logic [ZONE_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: design/afe_offset_calibration_sequencer.sv
// Top level of the front-end offset calibration sequencer: zone phase control,
// offset stepping and a registered result stage. Depends on aocs_pkg and the aocs_*_if interfaces.
//
//   channel  dir  payload                                         handshake
//   req      in   req_type, sample                                valid/ready
//   res      out  write_valid, reg_address, write_word, zone_index,
//                 zone_done, pos_offset_out, neg_offset_out,
//                 all_done                                        valid/ready
//   cfg      in   reg_index, wdata                                valid/ready (ready always high)
//
// One request per cycle while req.ready is high: the state update and the result are computed
// in the cycle the transaction is accepted; the result is in the output register the next cycle.
// req.ready is high while the output register is empty or being drained, so a stall on
// res holds the request side only while a result is waiting. Reset clears the phase,
// zone, offsets and the result valid, and loads differential mode 1 and zone count 12.
`default_nettype none
module afe_offset_calibration_sequencer #(
    parameter int MAX_ZONES = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    aocs_req_if.sink   req,
    aocs_res_if.source res,
    aocs_cfg_if.sink   cfg
);
    import aocs_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_POS  = 2'd1;
    localparam logic [1:0] PH_NEG  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [ZONE_W:0] ZoneLimit = (ZONE_W+1)'(MAX_ZONES);

    logic [1:0]          phase_reg, phase_next;
    logic [ZONE_W-1:0]   zone_reg, zone_next;
    logic [OFFSET_W-1:0] pos_reg, pos_next;
    logic [OFFSET_W-1:0] neg_reg, neg_next;
    logic                diff_mode_reg;
    logic [ZONE_W-1:0]   zone_count_reg;
    logic                res_valid_reg;
    res_t                res_reg, res_next;

    logic                accept;
    logic [ZONE_W:0]     zones_in_run;
    logic                last_zone;
    logic                wv;
    logic                done;
    logic [WORD_W-1:0]   word;
    logic [1:0]          ph;
    logic [OFFSET_W-1:0] pos_w, neg_w;

    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Clamp the zone count: zero counts as one, large values as the parameter.
    always_comb
    begin
        zones_in_run = {1'b0, zone_count_reg};
        if (zones_in_run == '0)
            zones_in_run = {{ZONE_W{1'b0}}, 1'b1};
        if (zones_in_run > ZoneLimit)
            zones_in_run = ZoneLimit;
    end

    assign last_zone = ({1'b0, zone_reg} + {{ZONE_W{1'b0}}, 1'b1}) >= zones_in_run;

    always_comb
    begin
        wv    = 1'b0;
        done  = 1'b0;
        word  = '0;
        ph    = phase_reg;
        pos_w = pos_reg;
        neg_w = neg_reg;
        zone_next = zone_reg;

        if (req.req_type == REQ_START)
        begin
            zone_next = '0;
            pos_w     = '0;
            neg_w     = '0;
            ph        = PH_POS;
        end
        else
        begin
            case (phase_reg)
                PH_POS:
                begin
                    if (req.sample > MID_LEVEL && pos_reg < OFFSET_MAX)
                    begin
                        pos_w = offset_step(pos_reg, req.sample);
                        wv    = 1'b1;
                        word  = {2'b00, pos_w, 8'h00};
                        done  = (pos_w == OFFSET_MAX);
                    end
                    else if (diff_mode_reg && pos_reg == '0)
                    begin
                        ph = PH_NEG;
                        if (req.sample < MID_LEVEL && neg_reg < OFFSET_MAX)
                        begin
                            neg_w = offset_step(neg_reg, req.sample);
                            wv    = 1'b1;
                            word  = {{(WORD_W-OFFSET_W){1'b0}}, neg_w};
                            done  = (neg_w == OFFSET_MAX);
                        end
                        else
                            done = 1'b1;
                    end
                    else
                        done = 1'b1;
                end
                PH_NEG:
                begin
                    if (req.sample < MID_LEVEL && neg_reg < OFFSET_MAX)
                    begin
                        neg_w = offset_step(neg_reg, req.sample);
                        wv    = 1'b1;
                        word  = {{(WORD_W-OFFSET_W){1'b0}}, neg_w};
                        done  = (neg_w == OFFSET_MAX);
                    end
                    else
                        done = 1'b1;
                end
                default:
                begin
                    // idle or finished: ignore the sample
                end
            endcase
        end

        res_next.write_valid    = wv;
        res_next.reg_address    = ADDR_BASE + {{(ADDR_W-ZONE_W-3){1'b0}}, zone_next, 3'b000};
        res_next.write_word     = word;
        res_next.zone_index     = zone_next;
        res_next.zone_done      = done;
        res_next.pos_offset_out = pos_w;
        res_next.neg_offset_out = neg_w;

        phase_next = ph;
        pos_next   = pos_w;
        neg_next   = neg_w;
        if (done)
        begin
            if (last_zone)
                phase_next = PH_DONE;
            else
            begin
                zone_next  = zone_reg + {{(ZONE_W-1){1'b0}}, 1'b1};
                pos_next   = '0;
                neg_next   = '0;
                phase_next = PH_POS;
            end
        end
        res_next.all_done = (phase_next == PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            zone_reg       <= '0;
            pos_reg        <= '0;
            neg_reg        <= '0;
            diff_mode_reg  <= 1'b1;
            zone_count_reg <= 4'd12;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                zone_reg  <= zone_next;
                pos_reg   <= pos_next;
                neg_reg   <= neg_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
                res_valid_reg <= 1'b0;

            if (cfg.valid)
            begin
                case (cfg.reg_index)
                    REG_DIFF_MODE:  diff_mode_reg  <= cfg.wdata[0];
                    REG_ZONE_COUNT: zone_count_reg <= cfg.wdata;
                    default:        zone_count_reg <= zone_count_reg;
                endcase
            end
        end
    end

    // Result payload: load on every accepted transaction, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.write_valid    = res_reg.write_valid;
    assign res.reg_address    = res_reg.reg_address;
    assign res.write_word     = res_reg.write_word;
    assign res.zone_index     = res_reg.zone_index;
    assign res.zone_done      = res_reg.zone_done;
    assign res.pos_offset_out = res_reg.pos_offset_out;
    assign res.neg_offset_out = res_reg.neg_offset_out;
    assign res.all_done       = res_reg.all_done;

endmodule
`default_nettype wire

FILE: verif/afe_offset_calibration_sequencer_tb.sv
// Self-checking testbench for afe_offset_calibration_sequencer: directed table, then
// randomised calibration runs under several idling and stall mixes, checked against a predictor.
// Depends on aocs_pkg and the aocs_req_if, aocs_res_if and aocs_cfg_if interfaces.
module afe_offset_calibration_sequencer_tb;
    import aocs_pkg::*;

    localparam int ZONE_LIMIT        = 12;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int ITEMS_PER_SETTING = 200;

    typedef enum logic [1:0] {CAL_IDLE, CAL_POS, CAL_NEG, CAL_DONE} cal_phase_e;
    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic              rtype;
        logic [SAMPLE_W-1:0] sample;
        logic              cfg_idx;
        logic [ZONE_W-1:0] cfg_data;
        logic              typed;
        res_t              want;
    } row_t;

    localparam res_t ZERO_RES       = '{reg_address: ADDR_BASE, default: '0};
    localparam res_t LONE_DONE_RES  = '{reg_address: ADDR_BASE, zone_done: 1'b1,
                                        all_done: 1'b1, default: '0};
    localparam res_t AFTER_DONE_RES = '{reg_address: ADDR_BASE, all_done: 1'b1, default: '0};

    // Threshold edges, saturation, quick zone ends, restart and run-count clamping.
    localparam row_t DIRECTED_ROWS [27] = '{
        '{ROW_REQ, REQ_SAMPLE, 16'h1234, 1'b0, 4'h0, 1'b1, ZERO_RES},
        '{ROW_REQ, REQ_START,  16'hFFFF, 1'b0, 4'h0, 1'b1, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hFFFF, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hE001, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hE000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hC001, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hC000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h9001, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h9000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h8000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hFFFF, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h7FFF, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h0000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h7FFE, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h8000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h8000, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h7FFF, 1'b0, 4'h0, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_START,  16'h0000, 1'b0, 4'h0, 1'b1, ZERO_RES},
        '{ROW_CFG, REQ_START,  16'h0000, REG_ZONE_COUNT, 4'h1, 1'b0, ZERO_RES},
        '{ROW_CFG, REQ_START,  16'h0000, REG_DIFF_MODE,  4'hE, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_START,  16'h5555, 1'b0, 4'h0, 1'b1, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h0000, 1'b0, 4'h0, 1'b1, LONE_DONE_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'hFFFF, 1'b0, 4'h0, 1'b1, AFTER_DONE_RES},
        '{ROW_CFG, REQ_START,  16'h0000, REG_ZONE_COUNT, 4'h0, 1'b0, ZERO_RES},
        '{ROW_CFG, REQ_START,  16'h0000, REG_DIFF_MODE,  4'h1, 1'b0, ZERO_RES},
        '{ROW_REQ, REQ_START,  16'hAAAA, 1'b0, 4'h0, 1'b1, ZERO_RES},
        '{ROW_REQ, REQ_SAMPLE, 16'h7FFF, 1'b0, 4'h0, 1'b1, LONE_DONE_RES}
    };

    localparam int IDLE_PCT [4]  = '{0, 59, 0, 29};
    localparam int STALL_PCT [4] = '{0, 0, 59, 29};
    localparam logic [ZONE_W-1:0] ZONE_COUNTS [6] = '{4'd12, 4'd1, 4'd15, 4'd0, 4'd2, 4'd13};

    logic clk;
    logic rst_n;

    aocs_req_if req_ch ();
    aocs_res_if res_ch ();
    aocs_cfg_if cfg_ch ();

    afe_offset_calibration_sequencer #(
        .MAX_ZONES (ZONE_LIMIT)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predictor state and configuration
    cal_phase_e          cal_phase;
    logic [ZONE_W-1:0]   cur_zone;
    logic [OFFSET_W-1:0] pos_off;
    logic [OFFSET_W-1:0] neg_off;
    logic                diff_mode;
    logic [ZONE_W-1:0]   zone_cnt;

    res_t calib_results_q [$];
    res_t last_result;
    int   mismatches;
    int   idle_cycles;
    int   send_idle_pct;
    int   stall_pct;
    int   zone_bias;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [OFFSET_W-1:0] grow_offset(input logic [OFFSET_W-1:0] off,
                                                        input logic [SAMPLE_W-1:0] s);
        int inc;
        int sum;
        if (s > 16'hE000)
            inc = 16;
        else if (s > 16'hC000)
            inc = 8;
        else if (s > 16'h9000)
            inc = 4;
        else
            inc = 1;
        sum = int'(off) + inc;
        return (sum > 63) ? 6'd63 : sum[OFFSET_W-1:0];
    endfunction

    // One negative-offset evaluation; returns 1 when the zone is finished.
    function automatic logic neg_update(input logic [SAMPLE_W-1:0] s, inout logic wv,
                                        inout logic [WORD_W-1:0] word);
        if (s < 16'h7FFF && neg_off < 6'd63)
        begin
            neg_off = grow_offset(neg_off, s);
            wv      = 1'b1;
            word    = {10'd0, neg_off};
            return neg_off == 6'd63;
        end
        return 1'b1;
    endfunction

    function automatic res_t calibrate_step(input logic rtype, input logic [SAMPLE_W-1:0] s);
        res_t              r;
        logic              wv;
        logic              fin;
        logic [WORD_W-1:0] word;
        int                zones;
        wv   = 1'b0;
        fin  = 1'b0;
        word = '0;
        if (rtype == REQ_START)
        begin
            cur_zone  = '0;
            pos_off   = '0;
            neg_off   = '0;
            cal_phase = CAL_POS;
        end
        else if (cal_phase == CAL_POS)
        begin
            if (s > 16'h7FFF && pos_off < 6'd63)
            begin
                pos_off = grow_offset(pos_off, s);
                wv      = 1'b1;
                word    = {2'b00, pos_off, 8'h00};
                fin     = (pos_off == 6'd63);
            end
            else if (diff_mode && pos_off == '0)
            begin
                cal_phase = CAL_NEG;
                fin       = neg_update(s, wv, word);
            end
            else
                fin = 1'b1;
        end
        else if (cal_phase == CAL_NEG)
            fin = neg_update(s, wv, word);

        r.write_valid    = wv;
        r.reg_address    = ADDR_BASE + (10'(cur_zone) << 3);
        r.write_word     = word;
        r.zone_index     = cur_zone;
        r.zone_done      = fin;
        r.pos_offset_out = pos_off;
        r.neg_offset_out = neg_off;

        if (fin)
        begin
            zones = (zone_cnt == '0) ? 1 : ((int'(zone_cnt) > ZONE_LIMIT) ? ZONE_LIMIT
                                                                          : int'(zone_cnt));
            if (int'(cur_zone) + 1 >= zones)
                cal_phase = CAL_DONE;
            else
            begin
                cur_zone  = cur_zone + 1'b1;
                pos_off   = '0;
                neg_off   = '0;
                cal_phase = CAL_POS;
            end
        end
        r.all_done = (cal_phase == CAL_DONE);
        return r;
    endfunction

    // Present one request, hold it until taken, then record the expected result.
    task automatic send_item(input logic rtype, input logic [SAMPLE_W-1:0] s, input logic typed,
                             input res_t want);
        res_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.sample   <= s;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted   = calibrate_step(rtype, s);
        last_result = predicted;
        calib_results_q.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Drop the request valid and wait until every expected result has been taken.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (calib_results_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ZONE_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_DIFF_MODE)
            diff_mode = data[0];
        else
            zone_cnt = data;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed runs; each zone leans towards positive, negative or mixed samples.
    task automatic pick_item(output logic rtype, output logic [SAMPLE_W-1:0] s);
        int r;
        r     = $urandom_range(0, 99);
        rtype = REQ_SAMPLE;
        s     = 16'($urandom);
        if (cal_phase == CAL_IDLE || cal_phase == CAL_DONE)
        begin
            if (r < 85)
                rtype = REQ_START;
        end
        else if (r < 2)
            rtype = REQ_START;
        else if (r >= 6)
        begin
            case (zone_bias)
                0:
                begin
                    if ($urandom_range(0, 11) == 0)
                        s = ($urandom_range(0, 1) == 0) ? 16'h7FFF
                                                        : 16'($urandom_range(0, 16'h7FFF));
                    else
                        s = 16'($urandom_range(16'h8000, 16'hFFFF));
                end
                1:
                begin
                    if ($urandom_range(0, 49) == 0)
                        s = 16'($urandom_range(16'h7FFF, 16'hFFFF));
                    else
                        s = 16'($urandom_range(0, 16'h7FFE));
                end
                default:
                    s = 16'($urandom);
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (calib_results_q.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = calib_results_q.pop_front();
                check_field("write_valid", 32'(want.write_valid), 32'(res_ch.write_valid));
                check_field("reg_address", 32'(want.reg_address), 32'(res_ch.reg_address));
                check_field("write_word", 32'(want.write_word), 32'(res_ch.write_word));
                check_field("zone_index", 32'(want.zone_index), 32'(res_ch.zone_index));
                check_field("zone_done", 32'(want.zone_done), 32'(res_ch.zone_done));
                check_field("pos_offset_out", 32'(want.pos_offset_out),
                            32'(res_ch.pos_offset_out));
                check_field("neg_offset_out", 32'(want.neg_offset_out),
                            32'(res_ch.neg_offset_out));
                check_field("all_done", 32'(want.all_done), 32'(res_ch.all_done));
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic              rt;
        logic [SAMPLE_W-1:0] s;
        logic [ZONE_W-1:0] zc;
        int                setting;
        int                counted;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_SAMPLE;
        req_ch.sample    = '0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = REG_DIFF_MODE;
        cfg_ch.wdata     = '0;
        cal_phase        = CAL_IDLE;
        cur_zone         = '0;
        pos_off          = '0;
        neg_off          = '0;
        diff_mode        = 1'b1;
        zone_cnt         = 4'd12;
        last_result      = ZERO_RES;
        mismatches       = 0;
        idle_cycles      = 0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        zone_bias        = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(DIRECTED_ROWS[i].cfg_idx, DIRECTED_ROWS[i].cfg_data);
            end
            else
                send_item(DIRECTED_ROWS[i].rtype, DIRECTED_ROWS[i].sample,
                          DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = IDLE_PCT[ph];
            stall_pct     = STALL_PCT[ph];
            for (int c = 0; c < 2; c++)
            begin
                setting = ph * 2 + c;
                zc = (setting >= 6) ? 4'($urandom_range(0, 15)) : ZONE_COUNTS[setting];
                write_reg(REG_ZONE_COUNT, zc);
                write_reg(REG_DIFF_MODE, {3'($urandom), ~setting[0]});
                counted = 0;
                while (counted < ITEMS_PER_SETTING)
                begin
                    pick_item(rt, s);
                    // samples outside a run are ignored by the block; leave them out of the count
                    if (rt == REQ_START || cal_phase == CAL_POS || cal_phase == CAL_NEG)
                        counted++;
                    send_item(rt, s, 1'b0, ZERO_RES);
                    if (rt == REQ_START || last_result.zone_done)
                        zone_bias = $urandom_range(0, 2);
                end
                drain_results();
            end
        end

        repeat (8) @(negedge clk);
        if (calib_results_q.size() != 0)
        begin
            $error("%0d expected results never arrived", calib_results_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
